[sv/touch_slot_tracker_defines.svh]
// Assertion macros used by the touch slot tracker datapath.
`ifndef TOUCH_SLOT_TRACKER_DEFINES_SVH
`define TOUCH_SLOT_TRACKER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TST_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("touch slot tracker assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define TST_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("touch slot tracker assertion failed");

`endif

[sv/tst_pkg.sv]
// Shared types and constants of the touch slot tracker.
package tst_pkg;

   localparam int SLOTS  = 8;
   localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [7:0] MOVE_RADIUS_RESET = 8'd5;

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_GET    = 2'd1,
      OP_OWN    = 2'd2,
      OP_FREE   = 2'd3
   } tst_op_type;

   typedef struct packed {
      tst_op_type         req_type;
      logic [2:0]         slot;
      logic               press_edge;
      logic               held;
      logic               release_edge;
      logic signed [15:0] window_x;
      logic signed [15:0] window_y;
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic [7:0]         req_id;
   } tst_req_type;

   typedef struct packed {
      logic               found;
      logic [2:0]         out_slot;
      logic               owned;
      logic               pressed;
      logic               moved;
      logic signed [15:0] cur_window_x;
      logic signed [15:0] cur_window_y;
      logic signed [15:0] cur_screen_x;
      logic signed [15:0] cur_screen_y;
      logic [7:0]         owner;
   } tst_rsp_type;

   // One entry of the slot table; positions hold x in the low half, y in the high half.
   typedef struct packed {
      logic        pressed;
      logic        moved;
      logic        unclaimed;
      logic        free_pending;
      logic        owned_flag;
      logic [7:0]  owner;
      logic [31:0] window_pos;
      logic [31:0] screen_pos;
      logic [31:0] start_pos;
   } tst_slot_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_APPLY
   } tst_state_type;

   typedef struct packed {
      logic capture;
      logic sq_x;
      logic sq_y;
      logic commit;
   } tst_cmd_type;

   typedef struct packed {
      logic out_blocked;
   } tst_status_type;

endpackage

[sv/tst_ctrl.sv]
// Sequencer of the touch slot tracker: accept, two squaring steps, commit.
module tst_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  tst_pkg::tst_status_type status,
   output tst_pkg::tst_cmd_type    cmd
);
   import tst_pkg::*;

   tst_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SQ_X;
         end
         ST_SQ_X: state_in = ST_SQ_Y;
         ST_SQ_Y: state_in = ST_APPLY;
         ST_APPLY: begin
            if (!status.out_blocked) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_SQ_X: cmd.sq_x = 1'b1;
         ST_SQ_Y: cmd.sq_y = 1'b1;
         ST_APPLY: cmd.commit = !status.out_blocked;
         default: ;
      endcase
   end

endmodule

[sv/tst_dp.sv]
// Datapath of the touch slot tracker: slot table, move check, slot search, result register.
`include "touch_slot_tracker_defines.svh"

module tst_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  tst_pkg::tst_req_type    req_data,
   input  tst_pkg::tst_cmd_type    cmd,
   output tst_pkg::tst_status_type status,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [7:0]              csr_wdata,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output tst_pkg::tst_rsp_type    rsp_data
);
   import tst_pkg::*;

   logic [7:0]        radius_ff, radius_in;
   logic [15:0]       rr_ff;
   tst_req_type       req_ff;
   tst_slot_type      entry_ff [SLOTS];
   logic              sel_valid_ff, sel_valid_in;
   logic [SIDX_W-1:0] sel_slot_ff, sel_slot_in;
   logic [7:0]        sel_req_ff, sel_req_in;
   logic [31:0]       sqx_ff, sqy_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   tst_rsp_type       rsp_data_ff, rsp_in;

   logic [SIDX_W-1:0] upd_idx, tgt, own_idx, unc_idx;
   logic              slot_ok, own_hit, unc_hit;
   logic [31:0]       start_pos;
   logic signed [16:0] dx, dy, mul_op;
   logic signed [33:0] mul_prod;
   logic [32:0]       dist_sq;
   logic              far;
   logic              we, emit;
   tst_slot_type      cur, nxt;

   assign csr_ready          = 1'b1;
   assign status.out_blocked = rsp_valid_ff && rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_data_ff;

   // Squared distance, one axis per cycle through a single multiplier.
   assign upd_idx   = SIDX_W'(req_ff.slot);
   assign slot_ok   = int'(req_ff.slot) < SLOTS;
   assign start_pos = entry_ff[upd_idx].start_pos;
   assign dx        = {req_ff.screen_x[15], req_ff.screen_x} - {start_pos[15], start_pos[15:0]};
   assign dy        = {req_ff.screen_y[15], req_ff.screen_y} - {start_pos[31], start_pos[31:16]};
   assign mul_op    = cmd.sq_y ? dy : dx;
   assign mul_prod  = mul_op * mul_op;
   assign dist_sq   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign far       = dist_sq > {17'd0, rr_ff};

   // Lowest claimed slot owned by the requester, and lowest unclaimed slot.
   always_comb begin
      own_hit = 1'b0;
      unc_hit = 1'b0;
      own_idx = '0;
      unc_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!entry_ff[i].unclaimed && entry_ff[i].owner == req_ff.req_id) begin
            own_hit = 1'b1;
            own_idx = SIDX_W'(i);
         end
         if (entry_ff[i].unclaimed) begin
            unc_hit = 1'b1;
            unc_idx = SIDX_W'(i);
         end
      end
   end

   always_comb begin
      tgt  = sel_slot_ff;
      emit = 1'b0;
      case (req_ff.req_type)
         OP_UPDATE: begin
            tgt  = upd_idx;
            emit = slot_ok;
         end
         OP_GET: begin
            tgt  = own_hit ? own_idx : unc_idx;
            emit = own_hit || unc_hit;
         end
         OP_OWN, OP_FREE: emit = sel_valid_ff;
         default: ;
      endcase
   end

   always_comb begin
      cur          = entry_ff[tgt];
      nxt          = cur;
      we           = emit;
      sel_valid_in = sel_valid_ff;
      sel_slot_in  = sel_slot_ff;
      sel_req_in   = sel_req_ff;
      case (req_ff.req_type)
         OP_UPDATE: begin
            if (req_ff.press_edge) begin
               nxt.pressed    = 1'b1;
               nxt.moved      = 1'b0;
               nxt.window_pos = {req_ff.window_y, req_ff.window_x};
               nxt.screen_pos = {req_ff.screen_y, req_ff.screen_x};
               nxt.start_pos  = {req_ff.screen_y, req_ff.screen_x};
               nxt.unclaimed  = 1'b1;
            end else if (req_ff.held) begin
               nxt.window_pos = {req_ff.window_y, req_ff.window_x};
               nxt.screen_pos = {req_ff.screen_y, req_ff.screen_x};
               if (!cur.moved) nxt.moved = far;
            end else if (req_ff.release_edge) begin
               nxt.pressed   = 1'b0;
               nxt.unclaimed = 1'b0;
            end
            if (cur.free_pending) begin
               nxt.owner        = '0;
               nxt.free_pending = 1'b0;
            end
         end
         OP_GET: begin
            nxt.owned_flag = own_hit;
            sel_valid_in   = own_hit || unc_hit;
            sel_slot_in    = emit ? tgt : sel_slot_ff;
            sel_req_in     = req_ff.req_id;
         end
         OP_OWN: begin
            nxt.unclaimed = 1'b0;
            nxt.owner     = sel_req_ff;
         end
         OP_FREE: nxt.free_pending = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      rsp_in = '0;
      if (emit) begin
         rsp_in.found        = 1'b1;
         rsp_in.out_slot     = 3'(tgt);
         rsp_in.owned        = nxt.owned_flag;
         rsp_in.pressed      = nxt.pressed;
         rsp_in.moved        = nxt.moved;
         rsp_in.cur_window_x = nxt.window_pos[15:0];
         rsp_in.cur_window_y = nxt.window_pos[31:16];
         rsp_in.cur_screen_x = nxt.screen_pos[15:0];
         rsp_in.cur_screen_y = nxt.screen_pos[31:16];
         rsp_in.owner        = nxt.owner;
      end
   end

   always_comb begin
      radius_in = csr_valid ? csr_wdata : radius_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= MOVE_RADIUS_RESET;
         sel_valid_ff <= 1'b0;
         sel_slot_ff  <= '0;
         sel_req_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            entry_ff[i] <= '0;
         end
      end else begin
         radius_ff    <= radius_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            sel_valid_ff <= sel_valid_in;
            sel_slot_ff  <= sel_slot_in;
            sel_req_ff   <= sel_req_in;
            if (we) entry_ff[tgt] <= nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      rr_ff <= {8'd0, radius_ff} * {8'd0, radius_ff};
      if (cmd.capture) req_ff <= req_data;
      if (cmd.sq_x) sqx_ff <= mul_prod[31:0];
      if (cmd.sq_y) sqy_ff <= mul_prod[31:0];
      if (cmd.commit) rsp_data_ff <= rsp_in;
   end

   `TST_ASSERT_IMP(a_commit_room, clock, reset, cmd.commit, !(rsp_valid_ff && rsp_stall))
   `TST_ASSERT_NXT(a_commit_shows, clock, reset, cmd.commit, rsp_valid_ff)
   `TST_ASSERT_IMP(a_empty_record, clock, reset, rsp_valid_ff && !rsp_data_ff.found,
                   rsp_data_ff == '0)
   `TST_ASSERT_IMP(a_sel_range, clock, reset, sel_valid_ff, int'(sel_slot_ff) < SLOTS)

endmodule

[sv/touch_slot_tracker.sv]
// Top level of the touch slot tracker: sequencer and datapath.
//
// The tracker keeps a table of eight touch slots and answers every request beat
// with exactly one result beat. An update beat applies one slot's press, hold or
// release sample; a get beat selects the lowest slot already claimed by the
// requester, or failing that the lowest unclaimed slot; own and free beats act on
// the slot that the last get selected. Each request passes from acceptance to the
// result register in order: it is accepted, the x and y screen distance from the
// press point is squared in turn in the single shared 17 by 17 multiplier, and the
// table is updated and the result register loaded once it no longer holds a
// stalled result. The next request is accepted in the cycle after that commit,
// while the result may still wait on the output register.
// The move radius register is written through the csr port, which is always
// ready; it should be written only while no request is in flight.
module touch_slot_tracker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tst_pkg::tst_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tst_pkg::tst_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [7:0]           csr_wdata
);
   import tst_pkg::*;

   // Commands from the sequencer and the output back-pressure status back to it.
   tst_cmd_type    cmd;
   tst_status_type status;

   // The sequencer steps each accepted beat through capture, squaring and commit.
   tst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the slot table, the selection and the result register.
   tst_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/touch_slot_tracker_test.sv]
// Self-checking testbench of the touch slot tracker: directed table, random traffic, predictor.
module touch_slot_tracker_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tst_pkg::*;

   // The run is stopped here if it hangs. About 700 beats, each with at worst a sender gap, the
   // work of the block and a full result stall, stay far below this limit on a clean run.
   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   tst_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   tst_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_wdata = '0;

   always #5ns clock = ~clock;

   touch_slot_tracker i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the slot table, the selection and the move radius. It is advanced once per
   // accepted request beat, in acceptance order, so it always matches the block's view.
   logic               trk_pressed   [SLOTS];
   logic               trk_moved     [SLOTS];
   logic               trk_unclaimed [SLOTS];
   logic               trk_free_pend [SLOTS];
   logic               trk_owned     [SLOTS];
   logic [7:0]         trk_owner     [SLOTS];
   logic signed [15:0] trk_win_x     [SLOTS];
   logic signed [15:0] trk_win_y     [SLOTS];
   logic signed [15:0] trk_scr_x     [SLOTS];
   logic signed [15:0] trk_scr_y     [SLOTS];
   logic signed [15:0] trk_start_x   [SLOTS];
   logic signed [15:0] trk_start_y   [SLOTS];
   bit                 sel_valid;
   int                 sel_slot;
   logic [7:0]         sel_requester;
   logic [7:0]         radius = MOVE_RADIUS_RESET;

   // Slot records still owed by the block, oldest first.
   tst_rsp_type pending_records[$];

   int  errors;
   int  n_updates, n_gets, n_owns, n_frees, n_moves, n_records, n_settings;
   bit  send_idle, recv_idle;
   int  stall_left;

   // Directed table: request, whether the record is typed in, and the typed record.
   tst_req_type dir_req[$];
   bit          dir_typed[$];
   tst_rsp_type dir_want[$];

   function automatic tst_rsp_type slot_record(input int s);
      tst_rsp_type rec;
      rec              = '0;
      rec.found        = 1'b1;
      rec.out_slot     = 3'(s);
      rec.owned        = trk_owned[s];
      rec.pressed      = trk_pressed[s];
      rec.moved        = trk_moved[s];
      rec.cur_window_x = trk_win_x[s];
      rec.cur_window_y = trk_win_y[s];
      rec.cur_screen_x = trk_scr_x[s];
      rec.cur_screen_y = trk_scr_y[s];
      rec.owner        = trk_owner[s];
      return rec;
   endfunction

   // Applies one request beat to the shadow table and returns the record it should produce.
   function automatic tst_rsp_type track_touch(input tst_req_type r);
      tst_rsp_type rec;
      int          s;
      longint      dx, dy;
      rec = '0;
      s   = r.slot;
      case (r.req_type)
         OP_UPDATE: begin
            n_updates++;
            if (s < SLOTS) begin
               if (r.press_edge) begin
                  trk_pressed[s]   = 1'b1;
                  trk_moved[s]     = 1'b0;
                  trk_win_x[s]     = r.window_x;
                  trk_win_y[s]     = r.window_y;
                  trk_scr_x[s]     = r.screen_x;
                  trk_scr_y[s]     = r.screen_y;
                  trk_start_x[s]   = r.screen_x;
                  trk_start_y[s]   = r.screen_y;
                  trk_unclaimed[s] = 1'b1;
               end else if (r.held) begin
                  trk_win_x[s] = r.window_x;
                  trk_win_y[s] = r.window_y;
                  trk_scr_x[s] = r.screen_x;
                  trk_scr_y[s] = r.screen_y;
                  // The moved flag latches; once set it is not reevaluated until the next press.
                  if (!trk_moved[s]) begin
                     dx = longint'(trk_scr_x[s]) - longint'(trk_start_x[s]);
                     dy = longint'(trk_scr_y[s]) - longint'(trk_start_y[s]);
                     trk_moved[s] = (dx * dx + dy * dy) > longint'(radius) * longint'(radius);
                     if (trk_moved[s]) n_moves++;
                  end
               end else if (r.release_edge) begin
                  trk_pressed[s]   = 1'b0;
                  trk_unclaimed[s] = 1'b0;
               end
               // A free requested earlier takes effect on the slot's next update.
               if (trk_free_pend[s]) begin
                  trk_owner[s]     = '0;
                  trk_free_pend[s] = 1'b0;
               end
               rec = slot_record(s);
            end
         end
         OP_GET: begin
            n_gets++;
            sel_requester = r.req_id;
            sel_valid     = 1'b0;
            // The requester's own claimed slot wins; requester zero matches ownerless slots.
            for (int i = 0; i < SLOTS; i++) begin
               if (!sel_valid && !trk_unclaimed[i] && trk_owner[i] == r.req_id) begin
                  trk_owned[i] = 1'b1;
                  sel_valid    = 1'b1;
                  sel_slot     = i;
               end
            end
            for (int i = 0; i < SLOTS; i++) begin
               if (!sel_valid && trk_unclaimed[i]) begin
                  trk_owned[i] = 1'b0;
                  sel_valid    = 1'b1;
                  sel_slot     = i;
               end
            end
         end
         OP_OWN: begin
            n_owns++;
            if (sel_valid) begin
               trk_unclaimed[sel_slot] = 1'b0;
               trk_owner[sel_slot]     = sel_requester;
            end
         end
         default: begin
            n_frees++;
            if (sel_valid) trk_free_pend[sel_slot] = 1'b1;
         end
      endcase
      if (r.req_type != OP_UPDATE && sel_valid) rec = slot_record(sel_slot);
      return rec;
   endfunction

   // Random request beat. Updates mostly follow press, hold and release with the hold points
   // scattered just inside and outside the move radius around the slot's start point; the
   // rest carries raw random content so that every bit of every field toggles.
   function automatic tst_req_type random_touch();
      logic [95:0] noise;
      tst_req_type r;
      int          pick, kind, span;
      noise = {$urandom, $urandom, $urandom};
      r     = noise[79:0];
      pick  = $urandom_range(0, 99);
      if (pick < 55) begin
         r.req_type = OP_UPDATE;
         kind = $urandom_range(0, 9);
         if (kind < 2) begin
            r.press_edge   = 1'b1;
         end else if (kind < 7) begin
            r.press_edge   = 1'b0;
            r.held         = 1'b1;
         end else if (kind < 9) begin
            r.press_edge   = 1'b0;
            r.held         = 1'b0;
            r.release_edge = 1'b1;
         end
         if ($urandom_range(0, 4) != 0) begin
            span = int'(radius) + 3;
            r.screen_x = 16'(int'(trk_start_x[r.slot]) + int'($urandom_range(0, 2 * span)) - span);
            r.screen_y = 16'(int'(trk_start_y[r.slot]) + int'($urandom_range(0, 2 * span)) - span);
         end
      end else if (pick < 75) begin
         r.req_type = OP_GET;
         // A small pool of requesters makes claims and own-slot matches frequent.
         if ($urandom_range(0, 4) != 0) r.req_id = 8'($urandom_range(0, 3));
      end else if (pick < 88) begin
         r.req_type = OP_OWN;
      end else begin
         r.req_type = OP_FREE;
      end
      return r;
   endfunction

   function automatic tst_req_type mk_req(input tst_op_type op, input int s, input bit p,
                                          input bit h, input bit rl, input int wx, input int wy,
                                          input int sx, input int sy, input int id);
      tst_req_type r;
      r.req_type     = op;
      r.slot         = 3'(s);
      r.press_edge   = p;
      r.held         = h;
      r.release_edge = rl;
      r.window_x     = 16'(wx);
      r.window_y     = 16'(wy);
      r.screen_x     = 16'(sx);
      r.screen_y     = 16'(sy);
      r.req_id       = 8'(id);
      return r;
   endfunction

   function automatic tst_rsp_type mk_rsp(input int s, input bit ow, input bit p, input bit mv,
                                          input int wx, input int wy, input int sx, input int sy,
                                          input int owner);
      tst_rsp_type rec;
      rec.found        = 1'b1;
      rec.out_slot     = 3'(s);
      rec.owned        = ow;
      rec.pressed      = p;
      rec.moved        = mv;
      rec.cur_window_x = 16'(wx);
      rec.cur_window_y = 16'(wy);
      rec.cur_screen_x = 16'(sx);
      rec.cur_screen_y = 16'(sy);
      rec.owner        = 8'(owner);
      return rec;
   endfunction

   task automatic add_row(input tst_req_type r, input bit typed, input tst_rsp_type want);
      dir_req.push_back(r);
      dir_typed.push_back(typed);
      dir_want.push_back(want);
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // Compares one accepted result beat with the oldest record still owed.
   task automatic check_record(input tst_rsp_type got);
      tst_rsp_type want;
      if (pending_records.size() == 0) begin
         $error("result beat arrived with no record expected");
         errors++;
      end else begin
         want = pending_records.pop_front();
         n_records++;
         check_field("found", want.found, got.found);
         check_field("out_slot", want.out_slot, got.out_slot);
         check_field("owned", want.owned, got.owned);
         check_field("pressed", want.pressed, got.pressed);
         check_field("moved", want.moved, got.moved);
         check_field("cur_window_x", want.cur_window_x, got.cur_window_x);
         check_field("cur_window_y", want.cur_window_y, got.cur_window_y);
         check_field("cur_screen_x", want.cur_screen_x, got.cur_screen_x);
         check_field("cur_screen_y", want.cur_screen_y, got.cur_screen_y);
         check_field("owner", want.owner, got.owner);
      end
   endtask

   // Result side: check every accepted beat, then hold stall high for a freshly drawn number
   // of cycles. The stall runs whether or not a beat is waiting, so it hits every phase.
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_record(rsp_data);
            stall_left = recv_idle ? $urandom_range(0, 7) : 0;
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // Request side: an optional gap with valid low, then one beat held until it is taken.
   // The record is predicted at the edge that accepts the beat.
   task automatic put_req(input tst_req_type r, input bit typed, input tst_rsp_type want);
      int          gap;
      tst_rsp_type model;
      gap = send_idle ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model = track_touch(r);
      pending_records.push_back(typed ? want : model);
   endtask

   // The radius is only changed with nothing in flight.
   task automatic set_radius(input logic [7:0] value);
      while (pending_records.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      radius = value;
      n_settings++;
   endtask

   // Sender and receiver idling are switched on and off in stretches.
   task automatic draw_idling();
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
   endtask

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timed out after %0d cycles with %0d records owed.", cycles,
               pending_records.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int radii[3];
      int beats[3];
      for (int i = 0; i < SLOTS; i++) begin
         trk_pressed[i]   = 1'b0;
         trk_moved[i]     = 1'b0;
         trk_unclaimed[i] = 1'b0;
         trk_free_pend[i] = 1'b0;
         trk_owned[i]     = 1'b0;
         trk_owner[i]     = '0;
         trk_win_x[i]     = '0;
         trk_win_y[i]     = '0;
         trk_scr_x[i]     = '0;
         trk_scr_y[i]     = '0;
         trk_start_x[i]   = '0;
         trk_start_y[i]   = '0;
      end
      sel_valid     = 1'b0;
      sel_slot      = 0;
      sel_requester = '0;

      // After reset every slot is claimed by nobody, so an unknown requester finds nothing
      // and own and free without a selection give an empty record.
      add_row(mk_req(OP_GET, 0, 0, 0, 0, 0, 0, 0, 0, 7), 1, '0);
      add_row(mk_req(OP_OWN, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '0);
      add_row(mk_req(OP_FREE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '0);
      // Press at the coordinate extremes, then a hold at the opposite corner must move.
      add_row(mk_req(OP_UPDATE, 7, 1, 0, 0, -32768, 32767, 32767, -32768, 0), 1,
              mk_rsp(7, 0, 1, 0, -32768, 32767, 32767, -32768, 0));
      add_row(mk_req(OP_UPDATE, 7, 0, 1, 0, 0, 0, -32768, 32767, 0), 1,
              mk_rsp(7, 0, 1, 1, 0, 0, -32768, 32767, 0));
      // Back at the start point the moved flag stays latched.
      add_row(mk_req(OP_UPDATE, 7, 0, 1, 0, 1, 1, 32767, -32768, 0), 0, '0);
      // Claim the unclaimed slot for requester 255, then find it again as its own.
      add_row(mk_req(OP_GET, 0, 0, 0, 0, 0, 0, 0, 0, 255), 0, '0);
      add_row(mk_req(OP_OWN, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
      add_row(mk_req(OP_GET, 0, 0, 0, 0, 0, 0, 0, 0, 255), 0, '0);
      // Requester zero matches the ownerless claimed slots.
      add_row(mk_req(OP_GET, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
      add_row(mk_req(OP_FREE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
      add_row(mk_req(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
      // A pending free drops the owner on the next update, here a release.
      add_row(mk_req(OP_GET, 0, 0, 0, 0, 0, 0, 0, 0, 255), 0, '0);
      add_row(mk_req(OP_FREE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
      add_row(mk_req(OP_UPDATE, 7, 0, 0, 1, 5, 5, 5, 5, 0), 0, '0);
      // Distance exactly at the radius does not count as moved; one step beyond it does.
      add_row(mk_req(OP_UPDATE, 2, 1, 0, 0, -1, -1, 100, 100, 0), 0, '0);
      add_row(mk_req(OP_UPDATE, 2, 0, 1, 0, 3, 4, 103, 104, 0), 0, '0);
      add_row(mk_req(OP_UPDATE, 2, 0, 1, 0, 3, 5, 103, 105, 0), 0, '0);
      // Press outranks hold and release; hold outranks release.
      add_row(mk_req(OP_UPDATE, 3, 1, 1, 1, 9, 9, -5, -5, 0), 0, '0);
      add_row(mk_req(OP_UPDATE, 3, 0, 1, 1, 8, 8, -5, 0, 0), 0, '0);
      add_row(mk_req(OP_UPDATE, 3, 0, 0, 1, 7, 7, 0, 0, 0), 0, '0);
      // A hold on a slot that was never pressed still measures against its start point.
      add_row(mk_req(OP_UPDATE, 4, 0, 1, 0, 2, 2, 6, 0, 0), 0, '0);
      add_row(mk_req(OP_GET, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
      add_row(mk_req(OP_GET, 0, 0, 0, 0, 0, 0, 0, 0, 200), 0, '0);
      add_row(mk_req(OP_OWN, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The directed table runs with the reset radius.
      draw_idling();
      foreach (dir_req[i]) put_req(dir_req[i], dir_typed[i], dir_want[i]);
      req_valid <= 1'b0;

      // Random traffic under both radius extremes and one value in between.
      radii = '{0, 255, int'($urandom_range(1, 254))};
      beats = '{200, 200, 250};
      foreach (radii[p]) begin
         set_radius(8'(radii[p]));
         for (int n = 0; n < beats[p]; n++) begin
            if (n % 40 == 0) draw_idling();
            put_req(random_touch(), 1'b0, '0);
         end
         req_valid <= 1'b0;
      end

      while (pending_records.size() != 0) @(posedge clock);
      // Then wait on, so that any stray result beat is caught.
      repeat (20) @(posedge clock);

      $display("Covered %0d request beats: %0d updates, %0d gets, %0d owns, %0d frees.",
               n_updates + n_gets + n_owns + n_frees, n_updates, n_gets, n_owns, n_frees);
      $display("%0d records checked, %0d touches crossed the radius, %0d radius writes.",
               n_records, n_moves, n_settings);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
